[design/mgr_pkg.sv]
// ----------------------------------------------------------------------------
// Module grid rasterizer package
// Shared field widths, codes and beat types for the grid rasterizer.
// ----------------------------------------------------------------------------
package mgr_pkg;

  // Field and register widths.
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned PIX_W     = 8;

  // Largest image side that is rendered; larger images are refused.
  localparam int unsigned MAX_SIDE = 4096;

  // Reset value of both image dimensions.
  localparam logic [CFG_W-1:0] IMAGE_SIDE_RESET = 13'd720;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Input beat kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Gray levels.
  localparam logic [PIX_W-1:0] PIX_BACKGROUND = 8'd255;
  localparam logic [PIX_W-1:0] PIX_DARK       = 8'd0;

  // Input beat.
  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] module_index;
    logic               module_value;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             request_error;
  } out_item_t;

  // Control that travels with an item through the pipeline.
  typedef struct packed {
    logic               is_write;
    logic [INDEX_W-1:0] widx;
    logic               wval;
    logic               err;
    logic               in_square;
  } ctl_t;

endpackage

[design/mgr_div_pipe.sv]
// ----------------------------------------------------------------------------
// Pipelined cell divider
// Two restoring dividers side by side, one quotient bit per stage, that turn
// the scaled x and y offsets into symbol cell coordinates.
// ----------------------------------------------------------------------------
module mgr_div_pipe
  import mgr_pkg::*;
#(
  parameter int unsigned QW = 6,
  parameter int unsigned NW = 18
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ctl_t                 in_ctl,
  input  logic [NW-1:0]        in_numx,
  input  logic [NW-1:0]        in_numy,
  input  logic [CFG_W-1:0]     in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ctl_t                 out_ctl,
  output logic [QW-1:0]        out_qx,
  output logic [QW-1:0]        out_qy
);

  localparam int unsigned CW = CFG_W + QW;

  typedef struct packed {
    ctl_t             ctl;
    logic [CFG_W-1:0] side;
    logic [NW-1:0]    remx;
    logic [NW-1:0]    remy;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    qy;
  } dstage_t;

  // One restoring step on both lanes for quotient bit k.
  function automatic dstage_t div_step(dstage_t s, int unsigned k);
    logic [CW-1:0] dsh;
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
    dstage_t       o;
    dsh = CW'(s.side) << k;
    rx  = CW'(s.remx);
    ry  = CW'(s.remy);
    o   = s;
    if (rx >= dsh) begin
      o.remx  = NW'(rx - dsh);
      o.qx[k] = 1'b1;
    end
    if (ry >= dsh) begin
      o.remy  = NW'(ry - dsh);
      o.qy[k] = 1'b1;
    end
    return o;
  endfunction

  dstage_t st_r  [QW];
  logic    v_r   [QW];
  dstage_t prev  [QW];
  logic    pv    [QW];
  logic    rdy   [QW+1];
  dstage_t src;

  // Entry beat: the numerators start as the remainders.
  always_comb begin
    src.ctl  = in_ctl;
    src.side = in_side;
    src.remx = in_numx;
    src.remy = in_numy;
    src.qx   = '0;
    src.qy   = '0;
  end

  assign rdy[QW] = out_ready;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    // A stage takes a new beat when it is empty or its beat moves on.
    assign rdy[j] = !v_r[j] || rdy[j+1];

    if (j == 0) begin : g_first
      assign prev[j] = src;
      assign pv[j]   = in_valid;
    end else begin : g_next
      assign prev[j] = st_r[j-1];
      assign pv[j]   = v_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= pv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && pv[j]) begin
        st_r[j] <= div_step(prev[j], QW - 1 - j);
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QW-1];
  assign out_ctl   = st_r[QW-1].ctl;
  assign out_qx    = st_r[QW-1].qx;
  assign out_qy    = st_r[QW-1].qy;

endmodule

[design/module_grid_rasterizer_top.sv]
// Pixel beats pass through stages A to D, the cell divider, stage E, the read stage F
// and the output register on the way to their result; module writes give no result.
// Throughput: one beat per cycle; the cell divider retires one quotient bit per stage.
// Stalls collapse bubbles stage by stage, so input is taken while the output waits.
// Reset (synchronous, active low) clears all valid bits and sets both image sides
// to 720; the module store holds no defined content until it is written.
// ----------------------------------------------------------------------------
// Module grid rasterizer top level
// Stores a square grid of one-bit modules and renders pixels of a gray image
// with the grid scaled into the largest centered square, quiet zone included.
// ----------------------------------------------------------------------------
module module_grid_rasterizer_top
  import mgr_pkg::*;
#(
  parameter int unsigned GRID_SIDE     = 32,
  parameter int unsigned QUIET_MODULES = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned SYM_CELLS    = GRID_SIDE + 2 * QUIET_MODULES;
  localparam int unsigned QW           = $clog2(SYM_CELLS);
  localparam int unsigned NW           = COORD_W + QW;
  localparam int unsigned GW           = $clog2(GRID_SIDE);
  localparam int unsigned GRID_CELLS   = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW           = $clog2(GRID_CELLS);
  localparam int unsigned XW           = CFG_W + 1;
  localparam logic [QW:0]   CELL_LO    = (QW+1)'(QUIET_MODULES);
  localparam logic [QW:0]   CELL_HI    = (QW+1)'(QUIET_MODULES + GRID_SIDE);
  localparam logic [QW-1:0] CELL_BASE  = QW'(QUIET_MODULES);

  typedef struct packed {
    ctl_t               ctl;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CFG_W-1:0]   w;
    logic [CFG_W-1:0]   h;
    logic [CFG_W-1:0]   side;
  } a_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CFG_W-1:0]   side;
    logic [CFG_W-1:0]   ox;
    logic [CFG_W-1:0]   oy;
  } b_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [CFG_W-1:0]   side;
    logic [COORD_W-1:0] offx;
    logic [COORD_W-1:0] offy;
  } c_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [CFG_W-1:0] side;
    logic [NW-1:0]    numx;
    logic [NW-1:0]    numy;
  } d_t;

  typedef struct packed {
    ctl_t          ctl;
    logic [AW-1:0] addr;
  } e_t;

  typedef struct packed {
    logic err;
    logic hit;
  } f_t;

  // Configuration registers.
  logic [CFG_W-1:0] img_w_r;
  logic [CFG_W-1:0] img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMAGE_SIDE_RESET;
      img_h_r <= IMAGE_SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_wdata;
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  a_t   a_r, a_nxt;
  b_t   b_r, b_nxt;
  c_t   c_r, c_nxt;
  d_t   d_r, d_nxt;
  e_t   e_r, e_nxt;
  f_t   f_r, f_nxt;
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g;
  logic rd_r;
  out_item_t out_r, out_nxt;
  logic      out_v_r;

  logic          div_in_ready;
  logic          div_out_valid;
  ctl_t          div_ctl;
  logic [QW-1:0] div_qx;
  logic [QW-1:0] div_qy;

  // Ready chain from the output register back to the input.
  assign rdy_g    = !out_v_r || out_ready;
  assign rdy_f    = !f_v_r || rdy_g;
  assign rdy_e    = !e_v_r || rdy_f;
  assign rdy_d    = !d_v_r || div_in_ready;
  assign rdy_c    = !c_v_r || rdy_d;
  assign rdy_b    = !b_v_r || rdy_c;
  assign rdy_a    = !a_v_r || rdy_b;
  assign in_ready = rdy_a;

  // Stage A: refusal checks and the side of the centered square.
  always_comb begin
    a_nxt.ctl.is_write  = (in_data.kind == KIND_WRITE);
    a_nxt.ctl.widx      = in_data.module_index;
    a_nxt.ctl.wval      = in_data.module_value;
    a_nxt.ctl.in_square = 1'b0;
    a_nxt.ctl.err       = (32'(img_w_r) < SYM_CELLS) || (32'(img_h_r) < SYM_CELLS) ||
                          (32'(img_w_r) > MAX_SIDE) || (32'(img_h_r) > MAX_SIDE) ||
                          (CFG_W'(in_data.pixel_x) >= img_w_r) ||
                          (CFG_W'(in_data.pixel_y) >= img_h_r);
    a_nxt.x             = in_data.pixel_x;
    a_nxt.y             = in_data.pixel_y;
    a_nxt.w             = img_w_r;
    a_nxt.h             = img_h_r;
    a_nxt.side          = (img_w_r < img_h_r) ? img_w_r : img_h_r;
  end

  // Stage B: margins beside the square.
  always_comb begin
    b_nxt.ctl  = a_r.ctl;
    b_nxt.x    = a_r.x;
    b_nxt.y    = a_r.y;
    b_nxt.side = a_r.side;
    b_nxt.ox   = (a_r.w - a_r.side) >> 1;
    b_nxt.oy   = (a_r.h - a_r.side) >> 1;
  end

  // Stage C: inside-square test and offsets into the square.
  always_comb begin
    logic [CFG_W-1:0] dx;
    logic [CFG_W-1:0] dy;
    dx                  = CFG_W'(b_r.x) - b_r.ox;
    dy                  = CFG_W'(b_r.y) - b_r.oy;
    c_nxt.ctl           = b_r.ctl;
    c_nxt.ctl.in_square = (CFG_W'(b_r.x) >= b_r.ox) && (CFG_W'(b_r.y) >= b_r.oy) &&
                          (XW'(b_r.x) < XW'(b_r.ox) + XW'(b_r.side)) &&
                          (XW'(b_r.y) < XW'(b_r.oy) + XW'(b_r.side));
    c_nxt.side          = b_r.side;
    c_nxt.offx          = dx[COORD_W-1:0];
    c_nxt.offy          = dy[COORD_W-1:0];
  end

  // Stage D: offsets scaled by the symbol side.
  always_comb begin
    d_nxt.ctl  = c_r.ctl;
    d_nxt.side = c_r.side;
    d_nxt.numx = NW'(c_r.offx) * NW'(SYM_CELLS);
    d_nxt.numy = NW'(c_r.offy) * NW'(SYM_CELLS);
  end

  // Stage registers ahead of the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
      if (rdy_d) d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) a_r <= a_nxt;
    if (rdy_b && a_v_r)    b_r <= b_nxt;
    if (rdy_c && b_v_r)    c_r <= c_nxt;
    if (rdy_d && c_v_r)    d_r <= d_nxt;
  end

  // Cell coordinates by division through the side of the square.
  mgr_div_pipe #(
    .QW (QW),
    .NW (NW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_v_r),
    .in_ready  (div_in_ready),
    .in_ctl    (d_r.ctl),
    .in_numx   (d_r.numx),
    .in_numy   (d_r.numy),
    .in_side   (d_r.side),
    .out_valid (div_out_valid),
    .out_ready (rdy_e),
    .out_ctl   (div_ctl),
    .out_qx    (div_qx),
    .out_qy    (div_qy)
  );

  // Stage E: quiet zone test and module address.
  always_comb begin
    logic          cx_ok;
    logic          cy_ok;
    logic [QW-1:0] mx_full;
    logic [QW-1:0] my_full;
    logic [GW-1:0] mx;
    logic [GW-1:0] my;
    cx_ok               = ({1'b0, div_qx} >= CELL_LO) && ({1'b0, div_qx} < CELL_HI);
    cy_ok               = ({1'b0, div_qy} >= CELL_LO) && ({1'b0, div_qy} < CELL_HI);
    mx_full             = div_qx - CELL_BASE;
    my_full             = div_qy - CELL_BASE;
    mx                  = mx_full[GW-1:0];
    my                  = my_full[GW-1:0];
    e_nxt.ctl           = div_ctl;
    e_nxt.ctl.in_square = div_ctl.in_square && cx_ok && cy_ok;
    e_nxt.addr          = AW'(my) * AW'(GRID_SIDE) + AW'(mx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (rdy_e) begin
      e_v_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && div_out_valid) e_r <= e_nxt;
  end

  // Module store: writes and reads are done in item order as beats leave stage E.
  logic          module_store_r [GRID_CELLS];
  logic [31:0]   widx_ext;
  logic [AW-1:0] waddr;
  logic          wr_en;

  assign widx_ext = 32'(e_r.ctl.widx);
  assign waddr    = widx_ext[AW-1:0];
  assign wr_en    = e_v_r && rdy_f && e_r.ctl.is_write && (widx_ext < GRID_CELLS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      module_store_r[waddr] <= e_r.ctl.wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f) begin
      rd_r <= module_store_r[e_r.addr];
    end
  end

  // Stage F: flags beside the read data; write beats end here.
  always_comb begin
    f_nxt.err = e_r.ctl.err;
    f_nxt.hit = e_r.ctl.in_square;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (rdy_f) begin
      f_v_r <= e_v_r && !e_r.ctl.is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f && e_v_r) f_r <= f_nxt;
  end

  // Output register.
  always_comb begin
    out_nxt.request_error = f_r.err;
    out_nxt.pixel_value   = (!f_r.err && f_r.hit && rd_r) ? PIX_DARK : PIX_BACKGROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_g) begin
      out_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_g && f_v_r) out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // A refused request always shows the background level.
  a_err_background: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.request_error |-> out_data.pixel_value == PIX_BACKGROUND)
    else $error("refused request with a non-background pixel");

  // Only the two gray levels are ever produced.
  a_two_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pixel_value == PIX_DARK ||
                   out_data.pixel_value == PIX_BACKGROUND))
    else $error("pixel level other than dark or background");

  // An empty output register means the whole ready chain is open.
  a_chain_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  // A stalled read stage keeps its flags and read data.
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    f_v_r && !rdy_g |=> f_v_r && $stable(f_r) && $stable(rd_r))
    else $error("read stage changed while stalled");

endmodule
